[hw/rtl/slt_pkg.sv]
// Shared token codes, character constants and keyword table for the script lexer.
`default_nettype none
package slt_pkg;

  typedef enum logic [5:0] {
    K_LPAREN   = 6'd0,  K_RPAREN  = 6'd1,  K_LBRACE = 6'd2,  K_RBRACE  = 6'd3,
    K_COMMA    = 6'd4,  K_DOT     = 6'd5,  K_MINUS  = 6'd6,  K_PLUS    = 6'd7,
    K_SEMI     = 6'd8,  K_SLASH   = 6'd9,  K_STAR   = 6'd10, K_BANG    = 6'd11,
    K_BANG_EQ  = 6'd12, K_EQ      = 6'd13, K_EQ_EQ  = 6'd14, K_GT      = 6'd15,
    K_GT_EQ    = 6'd16, K_LT      = 6'd17, K_LT_EQ  = 6'd18, K_STRING  = 6'd19,
    K_NUMBER   = 6'd20, K_IDENT   = 6'd21, K_AND    = 6'd22, K_CLASS   = 6'd23,
    K_ELSE     = 6'd24, K_FALSE   = 6'd25, K_FUN    = 6'd26, K_FOR     = 6'd27,
    K_IF       = 6'd28, K_NIL     = 6'd29, K_OR     = 6'd30, K_PRINT   = 6'd31,
    K_RETURN   = 6'd32, K_SUPER   = 6'd33, K_THIS   = 6'd34, K_TRUE    = 6'd35,
    K_VAR      = 6'd36, K_WHILE   = 6'd37, K_EOF    = 6'd38, K_ERR_CHAR = 6'd39,
    K_ERR_STR  = 6'd40
  } tok_kind_e;

  localparam int KIND_W = 6;
  localparam int NUM_KW = 16;
  localparam int WIN_W  = 48;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  localparam logic [WIN_W-1:0] KW_TEXT [NUM_KW] = '{
    WIN_W'("and"),  WIN_W'("class"),  WIN_W'("else"),  WIN_W'("false"),
    WIN_W'("fun"),  WIN_W'("for"),    WIN_W'("if"),    WIN_W'("nil"),
    WIN_W'("or"),   WIN_W'("print"),  WIN_W'("return"), WIN_W'("super"),
    WIN_W'("this"), WIN_W'("true"),   WIN_W'("var"),   WIN_W'("while")
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
  };

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  // short: word length fits in 3 bits and is at most six
  function automatic tok_kind_e word_kind(input logic [WIN_W-1:0] win,
                                          input logic short, input logic [2:0] len);
    tok_kind_e k;
    k = K_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (short && (len == KW_LEN[i]) && (win == KW_TEXT[i])) begin
        k = tok_kind_e'(KIND_W'(int'(K_AND) + i));
      end
    end
    word_kind = k;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/slt_in_if.sv]
// Input byte channel of the script lexer.
`default_nettype none
interface slt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_source;

  modport source (output valid, char_in, end_of_source, input ready);
  modport sink   (input valid, char_in, end_of_source, output ready);
endinterface
`default_nettype wire

[hw/rtl/slt_out_if.sv]
// Token record channel of the script lexer.
`default_nettype none
interface slt_out_if #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16
);
  logic                   valid;
  logic                   ready;
  logic [5:0]             token_kind;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [OFFSET_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   line_number;
  logic                   last_of_run;

  modport source (output valid, token_kind, start_offset, token_length, line_number,
                  last_of_run, input ready);
  modport sink   (input valid, token_kind, start_offset, token_length, line_number,
                  last_of_run, output ready);
endinterface
`default_nettype wire

[hw/rtl/slt_scan.sv]
// Front end: scanner state machine, one byte per beat, packs up to three records.
`default_nettype none
module slt_scan #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16,
  parameter int REC_W       = slt_pkg::KIND_W + 2 * OFFSET_BITS,
  parameter int BUN_W       = 2 + LINE_BITS + 3 * REC_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [7:0]       char_i,
  input  wire logic             eos_i,
  output logic                  push_o,
  input  wire logic             full_i,
  output logic [BUN_W-1:0]      bundle_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_OPER, M_SLASH, M_COMMENT, M_STRING, M_INT, M_INTDOT, M_FRAC, M_IDENT
  } mode_e;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  mode_e                       mode_q, mode_d;
  logic [OFFSET_BITS-1:0]      start_q, start_d, ofs_q, ofs_d;
  logic [LINE_BITS-1:0]        line_q, line_d;
  logic [7:0]                  pend_q, pend_d;
  logic [slt_pkg::WIN_W-1:0]   win_q, win_d;

  logic [OFFSET_BITS-1:0]      len, ofs_inc;
  logic                        dig, go_idle, accept;
  logic [1:0]                  n;
  slt_pkg::tok_kind_e          kind_a  [3];
  logic [OFFSET_BITS-1:0]      start_a [3];
  logic [OFFSET_BITS-1:0]      len_a   [3];
  slt_pkg::tok_kind_e          op_base;

  assign accept  = valid_i && ready_o;
  assign ready_o = !full_i;
  assign len     = ofs_q - start_q;
  assign ofs_inc = ofs_q + OFFSET_BITS'(1);
  assign dig     = !eos_i && slt_pkg::is_digit(char_i);

  always_comb begin
    case (pend_q)
      slt_pkg::CH_BANG: op_base = slt_pkg::K_BANG;
      slt_pkg::CH_EQ:   op_base = slt_pkg::K_EQ;
      slt_pkg::CH_GT:   op_base = slt_pkg::K_GT;
      default:          op_base = slt_pkg::K_LT;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    ofs_d   = ofs_q;
    line_d  = line_q;
    pend_d  = pend_q;
    win_d   = win_q;
    go_idle = 1'b0;
    n       = 2'd0;
    for (int i = 0; i < 3; i++) begin
      kind_a[i]  = slt_pkg::K_EOF;
      start_a[i] = '0;
      len_a[i]   = '0;
    end

    case (mode_q)
      M_OPER: begin
        if (!eos_i && char_i == slt_pkg::CH_EQ) begin
          kind_a[n] = slt_pkg::tok_kind_e'(op_base + 6'd1);
          start_a[n] = start_q; len_a[n] = OFFSET_BITS'(2); n = n + 2'd1;
          ofs_d = ofs_inc; mode_d = M_IDLE;
        end else begin
          kind_a[n] = op_base; start_a[n] = start_q; len_a[n] = OFFSET_BITS'(1);
          n = n + 2'd1; go_idle = 1'b1;
        end
      end
      M_SLASH: begin
        if (!eos_i && char_i == slt_pkg::CH_SLASH) begin
          mode_d = M_COMMENT; ofs_d = ofs_inc;
        end else begin
          kind_a[n] = slt_pkg::K_SLASH; start_a[n] = start_q; len_a[n] = OFFSET_BITS'(1);
          n = n + 2'd1; go_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (!eos_i && char_i != slt_pkg::CH_NL) ofs_d = ofs_inc;
        else go_idle = 1'b1;
      end
      M_STRING: begin
        if (eos_i) begin
          kind_a[n] = slt_pkg::K_ERR_STR; start_a[n] = start_q; len_a[n] = len;
          n = n + 2'd1; go_idle = 1'b1;
        end else begin
          if (char_i == slt_pkg::CH_QUOTE) begin
            kind_a[n] = slt_pkg::K_STRING; start_a[n] = start_q;
            len_a[n] = len + OFFSET_BITS'(1); n = n + 2'd1; mode_d = M_IDLE;
          end else if (char_i == slt_pkg::CH_NL) begin
            if (line_q != LINE_MAX) line_d = line_q + LINE_BITS'(1);
          end
          ofs_d = ofs_inc;
        end
      end
      M_INT: begin
        if (dig || (!eos_i && char_i == slt_pkg::CH_DOT)) begin
          if (!dig) mode_d = M_INTDOT;
          ofs_d = ofs_inc;
        end else begin
          kind_a[n] = slt_pkg::K_NUMBER; start_a[n] = start_q; len_a[n] = len;
          n = n + 2'd1; go_idle = 1'b1;
        end
      end
      M_INTDOT: begin
        if (dig) begin
          mode_d = M_FRAC; ofs_d = ofs_inc;
        end else begin
          kind_a[n] = slt_pkg::K_NUMBER; start_a[n] = start_q;
          len_a[n] = len - OFFSET_BITS'(1); n = n + 2'd1;
          kind_a[n] = slt_pkg::K_DOT; start_a[n] = ofs_q - OFFSET_BITS'(1);
          len_a[n] = OFFSET_BITS'(1); n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_FRAC: begin
        if (dig) ofs_d = ofs_inc;
        else begin
          kind_a[n] = slt_pkg::K_NUMBER; start_a[n] = start_q; len_a[n] = len;
          n = n + 2'd1; go_idle = 1'b1;
        end
      end
      M_IDENT: begin
        if (!eos_i && (slt_pkg::is_alpha(char_i) || slt_pkg::is_digit(char_i))) begin
          win_d = {win_q[slt_pkg::WIN_W-9:0], char_i};
          ofs_d = ofs_inc;
        end else begin
          kind_a[n] = slt_pkg::word_kind(win_q, (len <= OFFSET_BITS'(6)), len[2:0]);
          start_a[n] = start_q; len_a[n] = len; n = n + 2'd1; go_idle = 1'b1;
        end
      end
      default: go_idle = 1'b1;
    endcase

    if (go_idle) begin
      mode_d = M_IDLE;
      if (eos_i) begin
        kind_a[n] = slt_pkg::K_EOF; start_a[n] = ofs_q; len_a[n] = '0; n = n + 2'd1;
      end else begin
        start_d = ofs_q;
        ofs_d   = ofs_inc;
        case (char_i)
          "(", ")", "{", "}", ",", ".", "-", "+", ";", "*": begin
            case (char_i)
              "(":     kind_a[n] = slt_pkg::K_LPAREN;
              ")":     kind_a[n] = slt_pkg::K_RPAREN;
              "{":     kind_a[n] = slt_pkg::K_LBRACE;
              "}":     kind_a[n] = slt_pkg::K_RBRACE;
              ",":     kind_a[n] = slt_pkg::K_COMMA;
              ".":     kind_a[n] = slt_pkg::K_DOT;
              "-":     kind_a[n] = slt_pkg::K_MINUS;
              "+":     kind_a[n] = slt_pkg::K_PLUS;
              ";":     kind_a[n] = slt_pkg::K_SEMI;
              default: kind_a[n] = slt_pkg::K_STAR;
            endcase
            start_a[n] = ofs_q; len_a[n] = OFFSET_BITS'(1); n = n + 2'd1;
          end
          slt_pkg::CH_BANG, slt_pkg::CH_EQ, slt_pkg::CH_LT, slt_pkg::CH_GT: begin
            pend_d = char_i; mode_d = M_OPER;
          end
          slt_pkg::CH_SLASH: mode_d = M_SLASH;
          slt_pkg::CH_SP, slt_pkg::CH_CR, slt_pkg::CH_TAB: ;
          slt_pkg::CH_NL: if (line_q != LINE_MAX) line_d = line_q + LINE_BITS'(1);
          slt_pkg::CH_QUOTE: mode_d = M_STRING;
          default: begin
            if (slt_pkg::is_digit(char_i)) mode_d = M_INT;
            else if (slt_pkg::is_alpha(char_i)) begin
              win_d = slt_pkg::WIN_W'(char_i); mode_d = M_IDENT;
            end else begin
              kind_a[n] = slt_pkg::K_ERR_CHAR; start_a[n] = ofs_q;
              len_a[n] = OFFSET_BITS'(1); n = n + 2'd1;
            end
          end
        endcase
      end
    end
  end

  // records of one beat all carry the line before the beat
  assign bundle_o = {n, line_q,
                     kind_a[2], start_a[2], len_a[2],
                     kind_a[1], start_a[1], len_a[1],
                     kind_a[0], start_a[0], len_a[0]};
  assign push_o = accept && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= '0;
      ofs_q   <= '0;
      line_q  <= LINE_BITS'(1);
      pend_q  <= '0;
      win_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      ofs_q   <= ofs_d;
      line_q  <= line_d;
      pend_q  <= pend_d;
      win_q   <= win_d;
    end
  end

`ifndef ASSERT_OFF
  a_eos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eos_i |=> mode_q == M_IDLE) else $error("mode not idle after end of source");
  a_eos_ofs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eos_i |=> ofs_q == $past(ofs_q)) else $error("offset moved on end of source");
  a_eos_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eos_i |-> push_o) else $error("end of source without records");
  a_line_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> line_q >= $past(line_q)) else $error("line count went back");
`endif

endmodule
`default_nettype wire

[hw/rtl/slt_fifo.sv]
// Small register queue between scanner and record emitter.
`default_nettype none
module slt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/slt_emit.sv]
// Back end: walks the records of the queue head out one beat at a time.
`default_nettype none
module slt_emit #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16,
  parameter int REC_W       = slt_pkg::KIND_W + 2 * OFFSET_BITS,
  parameter int BUN_W       = 2 + LINE_BITS + 3 * REC_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire logic [BUN_W-1:0] bundle_i,
  output logic                  pop_o,
  slt_out_if.source             out_o
);

  logic [1:0]       idx_q, cnt;
  logic [REC_W-1:0] rec;
  logic             last, fire;

  assign cnt  = bundle_i[BUN_W-1 -: 2];
  assign rec  = bundle_i[idx_q * REC_W +: REC_W];
  assign last = (idx_q + 2'd1 == cnt);
  assign fire = out_o.valid && out_o.ready;

  assign out_o.valid        = !empty_i;
  assign out_o.token_kind   = rec[REC_W-1 -: slt_pkg::KIND_W];
  assign out_o.start_offset = rec[2*OFFSET_BITS-1 -: OFFSET_BITS];
  assign out_o.token_length = rec[OFFSET_BITS-1:0];
  assign out_o.line_number  = bundle_i[3*REC_W +: LINE_BITS];
  assign out_o.last_of_run  = last;
  assign pop_o              = fire && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (fire) idx_q <= last ? 2'd0 : idx_q + 2'd1;
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> idx_q < cnt) else $error("record index past bundle");
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == 2'd0) else $error("index left over on empty queue");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 2'd0) else $error("index not cleared after pop");
`endif

endmodule
`default_nettype wire

[hw/rtl/script_lexer_tokenizer.sv]
// Top level of the streaming script lexer.
// One source byte is taken per beat on in_i, every cycle while the two-entry queue has room;
// each byte yields zero to three token records (kind, start offset, length, line) that
// leave on out_o one per cycle while out_o.ready is high, last_of_run marking the final record
// of a byte. A byte giving one record or none sustains one byte per cycle while out_o.ready is
// high; a byte giving more records holds the output until all have left the registered queue.
`default_nettype none
module script_lexer_tokenizer #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  slt_in_if.sink    in_i,
  slt_out_if.source out_o
);

  localparam int REC_W = slt_pkg::KIND_W + 2 * OFFSET_BITS;
  localparam int BUN_W = 2 + LINE_BITS + 3 * REC_W;

  logic             push, full, pop, empty;
  logic [BUN_W-1:0] bun_in, bun_out;

  slt_scan #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_scan (
    .clk_i, .rst_ni,
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .char_i   (in_i.char_in),
    .eos_i    (in_i.end_of_source),
    .push_o   (push),
    .full_i   (full),
    .bundle_o (bun_in)
  );

  slt_fifo #(.WIDTH(BUN_W), .DEPTH(2)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (bun_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (bun_out)
  );

  slt_emit #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_emit (
    .clk_i, .rst_ni,
    .empty_i  (empty),
    .bundle_i (bun_out),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire
